// ----- rtl/core/vdq_pkg.sv -----
`default_nettype none

package vdq_pkg;

    // fixed field widths of the stream payload
    localparam int SC_W        = 6;
    localparam int DIR_W       = 5;
    localparam int OUT_TDATA_W = 8;

    // parameter defaults
    localparam int DEF_COORD_BITS    = 10;
    localparam int DEF_ANGLE_BITS    = 16;
    localparam int DEF_CORDIC_STAGES = 16;
    localparam int DEF_MAX_SECTORS   = 32;

    // atan(2^-i) as a fraction of a turn, 2^-32 turn per lsb
    localparam int ATAN_LEN = 32;
    localparam logic [31:0] ATAN_TURN32 [ATAN_LEN] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    // table entry rounded to angle_bits of turn fraction
    function automatic logic [23:0] stage_angle(input int idx, input int angle_bits);
        logic [32:0] t;
        t = {1'b0, ATAN_TURN32[idx % ATAN_LEN]} + (33'd1 << (31 - angle_bits));
        return 24'(t >> (32 - angle_bits));
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/vector_direction_quantizer.sv -----
// channel   dir  signals                                tdata fields, low bit up
// --------  ---  -------------------------------------  ---------------------------------
// request   in   i_s_tvalid o_s_tready i_s_tdata         source_row source_col target_row
//                                                        target_col sector_count, zero pad
// result    out  o_m_tvalid i_m_tready o_m_tdata         direction, zero pad
//
// one request per cycle unless the output stalls; registers in order: input register,
// one cordic cell per stage, a product stage and the output register.
// i_rst_n is synchronous and clears only the valid bits of the row.
// each register stage moves on when it is empty or its neighbor moves, so a
// stall at the output fills the bubbles first before o_s_tready drops.
`default_nettype none

module vector_direction_quantizer
    import vdq_pkg::*;
#(
    parameter int COORD_BITS    = DEF_COORD_BITS,
    parameter int ANGLE_BITS    = DEF_ANGLE_BITS,
    parameter int CORDIC_STAGES = DEF_CORDIC_STAGES,
    parameter int MAX_SECTORS   = DEF_MAX_SECTORS,
    localparam int IN_TDATA_W   = ((4 * COORD_BITS + SC_W + 7) / 8) * 8
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_s_tvalid,
    output logic                   o_s_tready,
    // source_row, source_col, target_row, target_col, sector_count, zero pad
    input  wire  [IN_TDATA_W-1:0]  i_s_tdata,
    output logic                   o_m_tvalid,
    input  wire                    i_m_tready,
    // direction, zero pad
    output logic [OUT_TDATA_W-1:0] o_m_tdata
);

    localparam int DW = COORD_BITS + CORDIC_STAGES + 3;
    localparam int NW = $clog2(MAX_SECTORS + 1);

    logic                  w_valid [CORDIC_STAGES+1];
    logic                  w_ready [CORDIC_STAGES+1];
    logic signed [DW-1:0]  w_x     [CORDIC_STAGES+1];
    logic signed [DW-1:0]  w_y     [CORDIC_STAGES+1];
    logic [ANGLE_BITS-1:0] w_z     [CORDIC_STAGES+1];
    logic                  w_hold  [CORDIC_STAGES+1];
    logic [NW-1:0]         w_n     [CORDIC_STAGES+1];
    logic [NW-1:0]         w_sector, w_out_n;

    // fold and scale the request
    vdq_front #(
        .COORD_BITS    (COORD_BITS),
        .ANGLE_BITS    (ANGLE_BITS),
        .CORDIC_STAGES (CORDIC_STAGES),
        .MAX_SECTORS   (MAX_SECTORS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_s_tvalid),
        .o_ready        (o_s_tready),
        .i_source_row   (i_s_tdata[0 +: COORD_BITS]),
        .i_source_col   (i_s_tdata[COORD_BITS +: COORD_BITS]),
        .i_target_row   (i_s_tdata[2 * COORD_BITS +: COORD_BITS]),
        .i_target_col   (i_s_tdata[3 * COORD_BITS +: COORD_BITS]),
        .i_sector_count (i_s_tdata[4 * COORD_BITS +: SC_W]),
        .o_valid        (w_valid[0]),
        .i_ready        (w_ready[0]),
        .o_x            (w_x[0]),
        .o_y            (w_y[0]),
        .o_z            (w_z[0]),
        .o_hold         (w_hold[0]),
        .o_n            (w_n[0])
    );

    // row of cordic cells
    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
        vdq_cordic_cell #(
            .STAGE      (g),
            .ANGLE_BITS (ANGLE_BITS),
            .DW         (DW),
            .NW         (NW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .o_ready (w_ready[g]),
            .i_x     (w_x[g]),
            .i_y     (w_y[g]),
            .i_z     (w_z[g]),
            .i_hold  (w_hold[g]),
            .i_n     (w_n[g]),
            .o_valid (w_valid[g+1]),
            .i_ready (w_ready[g+1]),
            .o_x     (w_x[g+1]),
            .o_y     (w_y[g+1]),
            .o_z     (w_z[g+1]),
            .o_hold  (w_hold[g+1]),
            .o_n     (w_n[g+1])
        );
    end

    // sector quantization and output register
    vdq_quant #(
        .ANGLE_BITS (ANGLE_BITS),
        .NW         (NW)
    ) u_quant (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_valid[CORDIC_STAGES]),
        .o_ready  (w_ready[CORDIC_STAGES]),
        .i_z      (w_z[CORDIC_STAGES]),
        .i_n      (w_n[CORDIC_STAGES]),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_sector (w_sector),
        .o_n      (w_out_n)
    );

    assign o_m_tdata = OUT_TDATA_W'(DIR_W'(w_sector));

`ifndef ASSERT_OFF
    // nothing comes out right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    // the row only refuses requests when the output is full and stalled
    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (o_m_tvalid && !i_m_tready))
        else $error("request refused without output stall");

    // sector index stays below the clamped sector count
    a_sector_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (w_out_n == '0 || w_sector < w_out_n))
        else $error("sector index out of range");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/vdq_front.sv -----
`default_nettype none

module vdq_front
    import vdq_pkg::*;
#(
    parameter int COORD_BITS    = DEF_COORD_BITS,
    parameter int ANGLE_BITS    = DEF_ANGLE_BITS,
    parameter int CORDIC_STAGES = DEF_CORDIC_STAGES,
    parameter int MAX_SECTORS   = DEF_MAX_SECTORS,
    localparam int DW           = COORD_BITS + CORDIC_STAGES + 3,
    localparam int NW           = $clog2(MAX_SECTORS + 1)
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_valid,
    output logic                       o_ready,
    input  wire  [COORD_BITS-1:0]      i_source_row,
    input  wire  [COORD_BITS-1:0]      i_source_col,
    input  wire  [COORD_BITS-1:0]      i_target_row,
    input  wire  [COORD_BITS-1:0]      i_target_col,
    input  wire  [SC_W-1:0]            i_sector_count,
    output logic                       o_valid,
    input  wire                        i_ready,
    output logic signed [DW-1:0]       o_x,
    output logic signed [DW-1:0]       o_y,
    output logic [ANGLE_BITS-1:0]      o_z,
    output logic                       o_hold,
    output logic [NW-1:0]              o_n
);

    logic                       r_valid;
    logic signed [DW-1:0]       r_x, r_y, n_x, n_y;
    logic [ANGLE_BITS-1:0]      r_z, n_z;
    logic                       r_hold, n_hold;
    logic [NW-1:0]              r_n, n_n;
    logic signed [COORD_BITS:0] drow, dcol, xa, ya;

    // deltas, half-plane fold and scaling into the cordic word
    always_comb begin
        drow   = $signed({1'b0, i_target_row}) - $signed({1'b0, i_source_row});
        dcol   = $signed({1'b0, i_target_col}) - $signed({1'b0, i_source_col});
        n_hold = (drow == '0);
        xa     = drow;
        ya     = dcol;
        n_z    = '0;
        if (n_hold) begin
            // straight along the column axis: quarter or three quarters turn
            n_z = dcol[COORD_BITS] ? ANGLE_BITS'(3) << (ANGLE_BITS - 2)
                                   : ANGLE_BITS'(1) << (ANGLE_BITS - 2);
        end else if (drow[COORD_BITS]) begin
            xa  = -drow;
            ya  = -dcol;
            n_z = ANGLE_BITS'(1) << (ANGLE_BITS - 1);
        end
        n_x = DW'(xa) <<< CORDIC_STAGES;
        n_y = DW'(ya) <<< CORDIC_STAGES;
        // clamp sector count
        if ({1'b0, i_sector_count} > 7'(MAX_SECTORS)) begin
            n_n = NW'(MAX_SECTORS);
        end else begin
            n_n = NW'(i_sector_count);
        end
    end

    assign o_ready = !r_valid || i_ready;

    // valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_z    <= n_z;
            r_hold <= n_hold;
            r_n    <= n_n;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;
    assign o_hold  = r_hold;
    assign o_n     = r_n;

endmodule

`default_nettype wire

// ----- rtl/core/vdq_cordic_cell.sv -----
`default_nettype none

module vdq_cordic_cell
    import vdq_pkg::*;
#(
    parameter int STAGE      = 0,
    parameter int ANGLE_BITS = DEF_ANGLE_BITS,
    parameter int DW         = 29,
    parameter int NW         = 6
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_valid,
    output logic                  o_ready,
    input  wire signed [DW-1:0]   i_x,
    input  wire signed [DW-1:0]   i_y,
    input  wire  [ANGLE_BITS-1:0] i_z,
    input  wire                   i_hold,
    input  wire  [NW-1:0]         i_n,
    output logic                  o_valid,
    input  wire                   i_ready,
    output logic signed [DW-1:0]  o_x,
    output logic signed [DW-1:0]  o_y,
    output logic [ANGLE_BITS-1:0] o_z,
    output logic                  o_hold,
    output logic [NW-1:0]         o_n
);

    localparam logic [ANGLE_BITS-1:0] ANG = ANGLE_BITS'(stage_angle(STAGE, ANGLE_BITS));

    logic                  r_valid;
    logic signed [DW-1:0]  r_x, r_y, n_x, n_y, xs, ys;
    logic [ANGLE_BITS-1:0] r_z, n_z;
    logic                  r_hold;
    logic [NW-1:0]         r_n;

    // one vectoring micro-rotation
    always_comb begin
        xs = i_x >>> STAGE;
        ys = i_y >>> STAGE;
        if (!i_y[DW-1]) begin
            n_x = i_x + ys;
            n_y = i_y - xs;
            n_z = i_z + ANG;
        end else begin
            n_x = i_x - ys;
            n_y = i_y + xs;
            n_z = i_z - ANG;
        end
        // fixed angle passes untouched
        if (i_hold) begin
            n_z = i_z;
        end
    end

    assign o_ready = !r_valid || i_ready;

    // valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_z    <= n_z;
            r_hold <= i_hold;
            r_n    <= i_n;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;
    assign o_hold  = r_hold;
    assign o_n     = r_n;

endmodule

`default_nettype wire

// ----- rtl/core/vdq_quant.sv -----
`default_nettype none

module vdq_quant
    import vdq_pkg::*;
#(
    parameter int ANGLE_BITS = DEF_ANGLE_BITS,
    parameter int NW         = 6
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_valid,
    output logic                  o_ready,
    input  wire  [ANGLE_BITS-1:0] i_z,
    input  wire  [NW-1:0]         i_n,
    output logic                  o_valid,
    input  wire                   i_ready,
    output logic [NW-1:0]         o_sector,
    output logic [NW-1:0]         o_n
);

    localparam int PW = ANGLE_BITS + NW + 1;

    logic                  r_p_valid, r_o_valid;
    logic                  w_p_ready;
    logic [ANGLE_BITS-1:0] a;
    logic [PW-1:0]         r_prod, n_prod;
    logic [NW-1:0]         r_p_n, r_o_n, r_sector, n_sector;
    logic [NW:0]           d;

    // rotate back by an eighth turn and scale by the sector count
    always_comb begin
        a      = i_z - (ANGLE_BITS'(1) << (ANGLE_BITS - 3));
        n_prod = PW'(a) * PW'(i_n) + (PW'(1) << (ANGLE_BITS - 1));
    end

    // round result wraps from n back to zero
    always_comb begin
        d = r_prod[PW-1 -: NW + 1];
        if (d >= {1'b0, r_p_n}) begin
            n_sector = NW'(d - {1'b0, r_p_n});
        end else begin
            n_sector = NW'(d);
        end
    end

    assign w_p_ready = !r_o_valid || i_ready;
    assign o_ready   = !r_p_valid || w_p_ready;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_p_valid <= i_valid;
            end
            if (w_p_ready) begin
                r_o_valid <= r_p_valid;
            end
        end
    end

    // product stage
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_prod <= n_prod;
            r_p_n  <= i_n;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (w_p_ready && r_p_valid) begin
            r_sector <= n_sector;
            r_o_n    <= r_p_n;
        end
    end

    assign o_valid  = r_o_valid;
    assign o_sector = r_sector;
    assign o_n      = r_o_n;

endmodule

`default_nettype wire

// ----- bench/vector_direction_quantizer_tb.sv -----
`timescale 1ns / 1ps

module vector_direction_quantizer_tb;
    import vdq_pkg::*;

    localparam int COORD_W      = DEF_COORD_BITS;
    localparam int IN_W         = ((4 * COORD_W + SC_W + 7) / 8) * 8;
    localparam int SECTOR_LIMIT = DEF_MAX_SECTORS;
    localparam int COORD_MAX    = (1 << COORD_W) - 1;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int SEGMENTS     = 6;
    localparam int SEGMENT_LEN  = 242;

    // turn fractions at 16 bits of angle
    localparam logic [15:0] QUARTER_TURN  = 16'h4000;
    localparam logic [15:0] HALF_TURN     = 16'h8000;
    localparam logic [15:0] THREE_QUARTER = 16'hC000;
    localparam logic [15:0] EIGHTH_TURN   = 16'h2000;

    // request layout, msb first so it maps straight onto tdata
    typedef struct packed {
        logic [IN_W-4*COORD_W-SC_W-1:0] pad;
        logic [SC_W-1:0]                sector_count;
        logic [COORD_W-1:0]             target_col;
        logic [COORD_W-1:0]             target_row;
        logic [COORD_W-1:0]             source_col;
        logic [COORD_W-1:0]             source_row;
    } dir_request_t;

    typedef struct packed {
        logic [OUT_TDATA_W-DIR_W-1:0] pad;
        logic [DIR_W-1:0]             direction;
    } dir_result_t;

    typedef struct {
        dir_request_t     req;
        logic [DIR_W-1:0] direction;
    } sector_expect_t;

    typedef enum {FLOW_RANDOM, FLOW_FREE, FLOW_SRC_GAPS, FLOW_SINK_STALLS} flow_t;

    logic         i_clk      = 1'b0;
    logic         i_rst_n    = 1'b0;
    logic         i_s_tvalid = 1'b0;
    dir_request_t s_req      = '0;
    logic         i_m_tready = 1'b0;
    wire          o_s_tready;
    wire          o_m_tvalid;
    wire [OUT_TDATA_W-1:0] o_m_tdata;

    dir_request_t   pending_q[$];
    sector_expect_t sector_q[$];
    flow_t          flow_mode = FLOW_RANDOM;
    logic           req_fire  = 1'b0;
    logic           res_fire  = 1'b0;
    int             issued    = 0;
    int             checked   = 0;
    int             errors    = 0;
    int             cycles    = 0;
    int             send_wait = 0;
    int             recv_wait = 0;

    vector_direction_quantizer i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        // source_row, source_col, target_row, target_col, sector_count, zero pad
        .i_s_tdata  (s_req),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        // direction, zero pad
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // expected sector index for one request
    function automatic logic [DIR_W-1:0] quantize_direction(input dir_request_t req);
        longint      drow;
        longint      dcol;
        longint      x;
        longint      y;
        longint      xs;
        longint      ys;
        logic [15:0] ang;
        logic [15:0] step;
        logic [15:0] rotated;
        int          n;
        longint      sector;
        drow = longint'(req.target_row) - longint'(req.source_row);
        dcol = longint'(req.target_col) - longint'(req.source_col);
        n = (req.sector_count > SECTOR_LIMIT) ? SECTOR_LIMIT : int'(req.sector_count);
        if (drow == 0) begin
            ang = (dcol >= 0) ? QUARTER_TURN : THREE_QUARTER;
        end else begin
            x   = drow;
            y   = dcol;
            ang = '0;
            // fold the left half plane onto the right one
            if (x < 0) begin
                x   = -x;
                y   = -y;
                ang = HALF_TURN;
            end
            x = x * 65536;
            y = y * 65536;
            for (int i = 0; i < 16; i++) begin
                xs   = x >>> i;
                ys   = y >>> i;
                step = 16'(({1'b0, ATAN_TURN32[i]} + 33'h8000) >> 16);
                if (y >= 0) begin
                    x   = x + ys;
                    y   = y - xs;
                    ang = ang + step;
                end else begin
                    x   = x - ys;
                    y   = y + xs;
                    ang = ang - step;
                end
            end
        end
        rotated = ang - EIGHTH_TURN;
        if (n == 0)
            return '0;
        sector = (longint'(rotated) * n + 32768) >>> 16;
        if (sector >= n)
            sector = sector - n;
        return DIR_W'(sector);
    endfunction

    function automatic int sender_gap();
        if (flow_mode == FLOW_RANDOM || flow_mode == FLOW_SRC_GAPS)
            return $urandom_range(0, 7);
        return 0;
    endfunction

    function automatic int receiver_stall();
        if (flow_mode == FLOW_RANDOM || flow_mode == FLOW_SINK_STALLS)
            return $urandom_range(0, 7);
        return 0;
    endfunction

    task automatic queue_request(input int sr, input int sc, input int tr, input int tc,
                                 input int n);
        dir_request_t req;
        req              = '0;
        req.source_row   = COORD_W'(sr);
        req.source_col   = COORD_W'(sc);
        req.target_row   = COORD_W'(tr);
        req.target_col   = COORD_W'(tc);
        req.sector_count = SC_W'(n);
        pending_q.push_back(req);
        issued++;
    endtask

    function automatic int pick_sectors();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return ($urandom_range(0, 1) != 0) ? 8 : 16;
        if (r < 8)
            return $urandom_range(1, SECTOR_LIMIT);
        if (r == 8)
            return $urandom_range(SECTOR_LIMIT + 1, (1 << SC_W) - 1);
        return $urandom_range(0, (1 << SC_W) - 1);
    endfunction

    function automatic int pick_extreme();
        int r;
        r = $urandom_range(0, 5);
        case (r)
            0: return 0;
            1: return 1;
            2: return COORD_MAX - 1;
            3: return COORD_MAX;
            4: return 512;
            default: return 511;
        endcase
    endfunction

    // mix of uniform, short, axis, diagonal and corner vectors
    task automatic queue_random_request();
        int kind;
        int sr;
        int sc;
        int tr;
        int tc;
        int k;
        kind = $urandom_range(0, 9);
        sr = $urandom_range(0, COORD_MAX);
        sc = $urandom_range(0, COORD_MAX);
        tr = $urandom_range(0, COORD_MAX);
        tc = $urandom_range(0, COORD_MAX);
        if (kind == 4 || kind == 5) begin
            sr = $urandom_range(8, COORD_MAX - 8);
            sc = $urandom_range(8, COORD_MAX - 8);
            tr = sr + $urandom_range(0, 16) - 8;
            tc = sc + $urandom_range(0, 16) - 8;
        end else if (kind == 6) begin
            if ($urandom_range(0, 1) != 0)
                tr = sr;
            else
                tc = sc;
        end else if (kind == 7) begin
            sr = $urandom_range(200, COORD_MAX - 200);
            sc = $urandom_range(200, COORD_MAX - 200);
            k  = $urandom_range(1, 200);
            tr = ($urandom_range(0, 1) != 0) ? sr + k : sr - k;
            tc = ($urandom_range(0, 1) != 0) ? sc + k : sc - k;
        end else if (kind == 8) begin
            sr = pick_extreme();
            sc = pick_extreme();
            tr = pick_extreme();
            tc = pick_extreme();
        end
        queue_request(sr, sc, tr, tc, pick_sectors());
    endtask

    // request driver, changes at the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            send_wait = 0;
        end else if (!i_s_tvalid || req_fire) begin
            if (req_fire)
                send_wait = sender_gap();
            if (send_wait > 0) begin
                send_wait--;
                i_s_tvalid <= 1'b0;
            end else if (pending_q.size() != 0) begin
                s_req      <= pending_q.pop_front();
                i_s_tvalid <= 1'b1;
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // result back-pressure
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            recv_wait = 0;
        end else begin
            if (res_fire)
                recv_wait = receiver_stall();
            if (recv_wait > 0) begin
                recv_wait--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // accept requests and check results at the rising edge
    always @(posedge i_clk) begin
        sector_expect_t exp_item;
        dir_result_t    res;
        req_fire <= i_s_tvalid && o_s_tready;
        res_fire <= o_m_tvalid && i_m_tready;
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                exp_item.req       = s_req;
                exp_item.direction = quantize_direction(s_req);
                sector_q.push_back(exp_item);
            end
            if (o_m_tvalid && i_m_tready) begin
                res = o_m_tdata;
                if (sector_q.size() == 0) begin
                    $display("%0t: unexpected result: expected none, actual %0d",
                             $time, res.direction);
                    errors++;
                end else begin
                    exp_item = sector_q.pop_front();
                    if (res.direction !== exp_item.direction) begin
                        $display("%0t: direction mismatch for request %h: expected %0d, actual %0d",
                                 $time, exp_item.req, exp_item.direction, res.direction);
                        errors++;
                    end
                    checked++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        // directed vectors: same point, axes, corners, sector count edges
        queue_request(500, 500, 500, 500, 8);
        queue_request(0, 0, 0, COORD_MAX, 8);
        queue_request(0, COORD_MAX, 0, 0, 16);
        queue_request(0, 0, COORD_MAX, 0, 8);
        queue_request(COORD_MAX, 0, 0, 0, 8);
        queue_request(COORD_MAX, COORD_MAX, 0, 0, 32);
        queue_request(0, 0, COORD_MAX, COORD_MAX, 32);
        queue_request(0, COORD_MAX, COORD_MAX, 0, 16);
        queue_request(COORD_MAX, 0, 0, COORD_MAX, 16);
        queue_request(10, 10, 20, 20, 8);
        queue_request(10, 10, 0, 20, 8);
        queue_request(100, 100, 101, 100, 0);
        queue_request(100, 100, 50, 170, 1);
        queue_request(100, 100, 130, 40, 33);
        queue_request(300, 700, 200, 100, 63);
        queue_request(5, 5, 5, 5, 0);
        queue_request(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 32);
        queue_request(0, 0, 1, COORD_MAX, 32);
        queue_request(512, 512, 511, 512, 32);
        queue_request(512, 512, 512, 511, 8);
        queue_request(0, 0, COORD_MAX, 1, 32);

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // hold the sender until the pipe is empty
        wait (checked == issued);

        for (int s = 0; s < SEGMENTS; s++) begin
            flow_mode = flow_t'(s % 4);
            for (int j = 0; j < SEGMENT_LEN; j++)
                queue_random_request();
            if (s == SEGMENTS / 2)
                wait (checked == issued);
        end
        flow_mode = FLOW_RANDOM;

        wait (checked == issued);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0 && sector_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
